[rtl/core/rci_pkg.sv]
// Shared types and constants for the ring capture cubic interpolation core.
// Used by the controller, the datapath, the interpolation unit and the top level.
// No dependencies.
package rci_pkg;

   // Capture store geometry.
   localparam int DEPTH     = 65536;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int EL_W      = $clog2(DEPTH + 1);
   localparam int LEN_MIN   = 4;

   // Configuration port.
   localparam int CSR_W     = 17;
   localparam int CSR_IDX_W = 1;
   localparam int CHAN_W    = 2;
   localparam int CHAN_STEREO = 2;

   // Request and response fields.
   localparam int SMP_W     = 16;
   localparam int IDX_W     = 18;
   localparam int FRAC_W    = 16;
   localparam int WPOS_W    = 16;

   // Read position wrapping and full reduction.
   localparam int POS_W     = IDX_W + 1;
   localparam int MAG_W     = IDX_W;
   localparam int CNT_W     = $clog2(MAG_W);

   // Interpolation arithmetic.
   localparam int FRAC_BITS  = 16;
   localparam int GUARD_BITS = 16;
   localparam int FETCH_TAPS = 4;
   localparam int C1_W       = SMP_W + 1;
   localparam int C2_W       = SMP_W + 4;
   localparam int C3_W       = SMP_W + 3;
   localparam int A_W        = 37;
   localparam int AH_W       = A_W - FRAC_BITS;
   localparam int PROD_W     = AH_W + FRAC_BITS + 1;
   localparam int RLO_W      = FRAC_BITS + 1;
   localparam int STEPS      = 3;
   localparam int STEP_W     = $clog2(STEPS);

   localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BUFFER_LENGTH = 1'b0,
      REG_NUM_CHANNELS  = 1'b1
   } reg_index_type;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              clear_en;
      logic              accept;
      logic              do_write;
      logic              wrap;
      logic              mod_step;
      logic              mod_fix;
      logic              seek;
      logic              rd_issue;
      logic              rd_capture;
      logic              coef;
      logic              mul_lo;
      logic              mul_hi;
      logic              acc;
      logic [STEP_W-1:0] step;
      logic              finish;
      logic              load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic in_range;
      logic clear_last;
      logic out_free;
   } status_type;

endpackage

[rtl/core/ring_capture_cubic_interp_core.sv]
// Ring capture store with Catmull-Rom cubic reads. Each write or read gives one response;
// no new request is taken until the previous response is loaded into the output register. A read makes
// 4 serial store reads, then 3 Horner steps (multiply low, multiply high, accumulate) on one
// multiplier per channel, after a bit-serial modulo reduction when the index needs it.
// Reset is synchronous: afterwards both stores are cleared one slot per cycle over all
// 65536 slots, during which requests stall; configuration writes are taken at any time.
module ring_capture_cubic_interp_core import rci_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_action,
   input  logic signed [SMP_W-1:0] req_sample_left,
   input  logic signed [SMP_W-1:0] req_sample_right,
   input  logic                    req_hold_capture,
   input  logic signed [IDX_W-1:0] req_read_index,
   input  logic [FRAC_W-1:0]       req_read_fraction,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SMP_W-1:0] rsp_left_value,
   output logic signed [SMP_W-1:0] rsp_right_value,
   output logic [WPOS_W-1:0]       rsp_write_position
);

   cmd_type    cmd;
   status_type status;

   rci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rci_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_action         (req_action),
      .req_sample_left    (req_sample_left),
      .req_sample_right   (req_sample_right),
      .req_hold_capture   (req_hold_capture),
      .req_read_index     (req_read_index),
      .req_read_fraction  (req_read_fraction),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_left_value     (rsp_left_value),
      .rsp_right_value    (rsp_right_value),
      .rsp_write_position (rsp_write_position)
   );

endmodule

[rtl/core/rci_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for both capture stores.
module rci_ram #(
   parameter int DATA_W = 16,
   parameter int WORDS  = 64,
   localparam int AW    = $clog2(WORDS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [WORDS];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

[rtl/core/rci_interp.sv]
// Catmull-Rom interpolation unit for one channel: sample window, coefficients and
// a shared multiplier that runs the three Horner steps in two partial products each.
// Depends on rci_pkg.
module rci_interp import rci_pkg::*; (
   input  logic                    clock,
   input  cmd_type                 cmd,
   input  logic [SMP_W-1:0]        rd_data,
   input  logic [FRAC_W-1:0]       fraction,
   output logic signed [SMP_W-1:0] value
);

   logic signed [SMP_W-1:0]  y_ff [FETCH_TAPS];
   logic signed [SMP_W-1:0]  y_in [FETCH_TAPS];
   logic signed [C1_W-1:0]   c1_ff, c1_in;
   logic signed [C2_W-1:0]   c2_ff, c2_in;
   logic signed [A_W-1:0]    a_ff, a_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [RLO_W-1:0]         rlo_ff, rlo_in;
   logic signed [SMP_W-1:0]  value_ff, value_in;

   logic signed [AH_W-1:0]        seg;
   logic signed [FRAC_BITS:0]     frac_s;
   logic signed [PROD_W-1:0]      mul_res;

   assign frac_s = $signed({1'b0, fraction[FRAC_BITS-1:0]});

   // The low segment of the accumulator is unsigned; the high segment carries the sign.
   assign seg = cmd.mul_hi ? $signed(a_ff[A_W-1:FRAC_BITS])
                           : $signed({{(AH_W-FRAC_BITS){1'b0}}, a_ff[FRAC_BITS-1:0]});
   assign mul_res = seg * frac_s;

   always_comb begin
      logic signed [C3_W-1:0]   d_out, d_in, c3;
      logic [2*FRAC_BITS:0]     lo_sum;
      logic signed [PROD_W-1:0] addend, sum;
      logic signed [A_W:0]      t, rsh, r;
      y_in     = y_ff;
      c1_in    = c1_ff;
      c2_in    = c2_ff;
      a_in     = a_ff;
      prod_in  = prod_ff;
      rlo_in   = rlo_ff;
      value_in = value_ff;
      d_out    = C3_W'(y_ff[3]) - C3_W'(y_ff[0]);
      d_in     = C3_W'(y_ff[1]) - C3_W'(y_ff[2]);
      c3       = d_out + d_in + (d_in <<< 1);
      lo_sum   = {1'b0, prod_ff[2*FRAC_BITS-1:0]} + (2*FRAC_BITS+1)'(1 << (FRAC_BITS-1));
      case (cmd.step)
         STEP_W'(0): addend = PROD_W'(c2_ff) <<< GUARD_BITS;
         STEP_W'(1): addend = PROD_W'(c1_ff) <<< GUARD_BITS;
         default:    addend = '0;
      endcase
      sum = prod_ff + PROD_W'($signed({1'b0, rlo_ff})) + addend;
      t   = (A_W+1)'(a_ff) + (A_W+1)'(1 << GUARD_BITS);
      rsh = t >>> (GUARD_BITS + 1);
      r   = rsh + (A_W+1)'(y_ff[1]);

      if (cmd.rd_capture) begin
         for (int k = 0; k < FETCH_TAPS - 1; k++) begin
            y_in[k] = y_ff[k+1];
         end
         y_in[FETCH_TAPS-1] = $signed(rd_data);
      end
      if (cmd.coef) begin
         c1_in = C1_W'(y_ff[2]) - C1_W'(y_ff[0]);
         c2_in = (C2_W'(y_ff[0]) <<< 1) - (C2_W'(y_ff[1]) <<< 2) - C2_W'(y_ff[1])
               + (C2_W'(y_ff[2]) <<< 2) - C2_W'(y_ff[3]);
         a_in  = A_W'(c3) <<< GUARD_BITS;
      end
      if (cmd.mul_lo) begin
         prod_in = mul_res;
      end
      if (cmd.mul_hi) begin
         prod_in = mul_res;
         rlo_in  = lo_sum[2*FRAC_BITS:FRAC_BITS];
      end
      if (cmd.acc) begin
         a_in = A_W'(sum);
      end
      if (cmd.finish) begin
         if (r > (A_W+1)'(SMP_MAX)) begin
            value_in = SMP_MAX;
         end else if (r < (A_W+1)'(SMP_MIN)) begin
            value_in = SMP_MIN;
         end else begin
            value_in = SMP_W'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff     <= y_in;
      c1_ff    <= c1_in;
      c2_ff    <= c2_in;
      a_ff     <= a_in;
      prod_ff  <= prod_in;
      rlo_ff   <= rlo_in;
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

[rtl/core/rci_datapath.sv]
// Datapath: configuration registers, capture stores, write pointer, read position
// reduction, neighbor addressing, two interpolation units and the response register.
// Depends on rci_pkg, rci_ram and rci_interp.
module rci_datapath import rci_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    csr_write_enable,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]        csr_write_data,
   input  logic                    req_action,
   input  logic signed [SMP_W-1:0] req_sample_left,
   input  logic signed [SMP_W-1:0] req_sample_right,
   input  logic                    req_hold_capture,
   input  logic signed [IDX_W-1:0] req_read_index,
   input  logic [FRAC_W-1:0]       req_read_fraction,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic signed [SMP_W-1:0] rsp_left_value,
   output logic signed [SMP_W-1:0] rsp_right_value,
   output logic [WPOS_W-1:0]       rsp_write_position
);

   typedef struct packed {
      logic                    action;
      logic signed [SMP_W-1:0] sample_left;
      logic signed [SMP_W-1:0] sample_right;
      logic                    hold;
      logic signed [IDX_W-1:0] read_index;
      logic [FRAC_W-1:0]       read_fraction;
   } req_type;

   logic [CSR_W-1:0]        len_reg_ff, len_reg_in;
   logic [CHAN_W-1:0]       chan_ff, chan_in;
   logic [ADDR_W-1:0]       wp_ff, wp_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic                    out_valid_ff, out_valid_in;
   req_type                 req_ff, req_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [EL_W-1:0]         rem_ff, rem_in;
   logic [ADDR_W-1:0]       i1_ff, i1_in;
   logic [ADDR_W-1:0]       rd_addr_ff, rd_addr_in;
   logic signed [SMP_W-1:0] out_left_ff, out_left_in;
   logic signed [SMP_W-1:0] out_right_ff, out_right_in;
   logic [WPOS_W-1:0]       out_wpos_ff, out_wpos_in;

   logic [EL_W-1:0]         eff_len;
   logic                    mono;
   logic                    is_read;
   logic signed [POS_W-1:0] idx_w, len_s, p1;
   logic                    in_range;
   logic [ADDR_W-1:0]       wr_slot, wp_next;
   logic                    ram_we_left, ram_we_right;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [SMP_W-1:0]        ram_wdata_left, ram_wdata_right;
   logic [SMP_W-1:0]        rdata_left, rdata_right;
   logic signed [SMP_W-1:0] value_left, value_right;

   always_comb begin
      if (len_reg_ff < CSR_W'(LEN_MIN)) begin
         eff_len = EL_W'(LEN_MIN);
      end else if (len_reg_ff > CSR_W'(DEPTH)) begin
         eff_len = EL_W'(DEPTH);
      end else begin
         eff_len = EL_W'(len_reg_ff);
      end
   end

   assign mono    = chan_ff < CHAN_W'(CHAN_STEREO);
   assign is_read = action_type'(req_ff.action) == ACT_READ;

   // One add or subtract of the length brings a sane index into range.
   assign idx_w = POS_W'($signed(req_ff.read_index));
   assign len_s = $signed(POS_W'(eff_len));
   always_comb begin
      if (idx_w < 0) begin
         p1 = idx_w + len_s;
      end else if (idx_w >= len_s) begin
         p1 = idx_w - len_s;
      end else begin
         p1 = idx_w;
      end
   end
   assign in_range = !p1[POS_W-1] && (p1 < len_s);

   // A pointer left beyond a shrunken length restarts at slot zero.
   assign wr_slot = (EL_W'(wp_ff) >= eff_len) ? '0 : wp_ff;
   assign wp_next = ((EL_W'(wr_slot) + EL_W'(1)) == eff_len) ? '0 : wr_slot + ADDR_W'(1);

   always_comb begin
      logic [EL_W:0] t;
      len_reg_in   = len_reg_ff;
      chan_in      = chan_ff;
      wp_in        = wp_ff;
      clr_addr_in  = clr_addr_ff;
      req_in       = req_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      i1_in        = i1_ff;
      rd_addr_in   = rd_addr_ff;
      out_left_in  = out_left_ff;
      out_right_in = out_right_ff;
      out_wpos_in  = out_wpos_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      t            = {rem_ff, mag_ff[MAG_W-1]};

      if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_BUFFER_LENGTH: len_reg_in = csr_write_data;
            REG_NUM_CHANNELS:  chan_in    = csr_write_data[CHAN_W-1:0];
         endcase
      end
      if (cmd.clear_en) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end
      if (cmd.accept) begin
         req_in.action        = req_action;
         req_in.sample_left   = req_sample_left;
         req_in.sample_right  = req_sample_right;
         req_in.hold          = req_hold_capture;
         req_in.read_index    = req_read_index;
         req_in.read_fraction = req_read_fraction;
      end
      if (cmd.do_write && !req_ff.hold) begin
         wp_in = wp_next;
      end
      if (cmd.wrap) begin
         i1_in  = ADDR_W'(p1);
         neg_in = p1[POS_W-1];
         mag_in = p1[POS_W-1] ? MAG_W'(-p1) : MAG_W'(p1);
         rem_in = '0;
      end
      // Restoring remainder, one bit of the magnitude per cycle.
      if (cmd.mod_step) begin
         rem_in = (t >= {1'b0, eff_len}) ? EL_W'(t - {1'b0, eff_len}) : EL_W'(t);
         mag_in = mag_ff << 1;
      end
      if (cmd.mod_fix) begin
         i1_in = (neg_ff && rem_ff != '0) ? ADDR_W'(eff_len - rem_ff) : ADDR_W'(rem_ff);
      end
      if (cmd.seek) begin
         rd_addr_in = (i1_ff == '0) ? ADDR_W'(eff_len - EL_W'(1)) : i1_ff - ADDR_W'(1);
      end
      if (cmd.rd_issue) begin
         rd_addr_in = ((EL_W'(rd_addr_ff) + EL_W'(1)) == eff_len) ? '0
                    : rd_addr_ff + ADDR_W'(1);
      end
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_wpos_in  = WPOS_W'(wp_ff);
         if (is_read) begin
            out_left_in  = value_left;
            out_right_in = mono ? value_left : value_right;
         end else begin
            out_left_in  = '0;
            out_right_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_reg_ff   <= CSR_W'(DEPTH);
         chan_ff      <= CHAN_W'(CHAN_STEREO);
         wp_ff        <= '0;
         clr_addr_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         len_reg_ff   <= len_reg_in;
         chan_ff      <= chan_in;
         wp_ff        <= wp_in;
         clr_addr_ff  <= clr_addr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      rem_ff       <= rem_in;
      i1_ff        <= i1_in;
      rd_addr_ff   <= rd_addr_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
      out_wpos_ff  <= out_wpos_in;
   end

   assign ram_we_left     = cmd.clear_en || (cmd.do_write && !req_ff.hold);
   assign ram_we_right    = cmd.clear_en || (cmd.do_write && !req_ff.hold && !mono);
   assign ram_waddr       = cmd.clear_en ? clr_addr_ff : wr_slot;
   assign ram_wdata_left  = cmd.clear_en ? '0 : req_ff.sample_left;
   assign ram_wdata_right = cmd.clear_en ? '0 : req_ff.sample_right;

   rci_ram #(.DATA_W(SMP_W), .WORDS(DEPTH)) u_left_store (
      .clock   (clock),
      .wr_en   (ram_we_left),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_left),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr_ff),
      .rd_data (rdata_left)
   );

   rci_ram #(.DATA_W(SMP_W), .WORDS(DEPTH)) u_right_store (
      .clock   (clock),
      .wr_en   (ram_we_right),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata_right),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_addr_ff),
      .rd_data (rdata_right)
   );

   rci_interp u_interp_left (
      .clock    (clock),
      .cmd      (cmd),
      .rd_data  (rdata_left),
      .fraction (req_ff.read_fraction),
      .value    (value_left)
   );

   rci_interp u_interp_right (
      .clock    (clock),
      .cmd      (cmd),
      .rd_data  (rdata_right),
      .fraction (req_ff.read_fraction),
      .value    (value_right)
   );

   assign status.is_read    = is_read;
   assign status.in_range   = in_range;
   assign status.clear_last = clr_addr_ff == ADDR_W'(DEPTH - 1);
   assign status.out_free   = !out_valid_ff || !rsp_stall;

   assign rsp_valid          = out_valid_ff;
   assign rsp_left_value     = out_left_ff;
   assign rsp_right_value    = out_right_ff;
   assign rsp_write_position = out_wpos_ff;

endmodule

[rtl/core/rci_ctrl.sv]
// Controller state machine: store clearing, request sequencing and response hand-off.
// Depends on rci_pkg; drives the datapath through cmd_type and reads status_type.
module rci_ctrl import rci_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [13:0] {
      S_CLEAR   = 14'b00000000000001,
      S_IDLE    = 14'b00000000000010,
      S_START   = 14'b00000000000100,
      S_MOD     = 14'b00000000001000,
      S_MOD_FIX = 14'b00000000010000,
      S_SEEK    = 14'b00000000100000,
      S_FETCH   = 14'b00000001000000,
      S_COEF    = 14'b00000010000000,
      S_MUL_LO  = 14'b00000100000000,
      S_MUL_HI  = 14'b00001000000000,
      S_ACC     = 14'b00010000000000,
      S_FINISH  = 14'b00100000000000,
      S_OUTPUT  = 14'b01000000000000,
      S_SPARE   = 14'b10000000000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.step = step_ff;

      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_START;
            end
         end
         S_START: begin
            cnt_in = '0;
            if (status.is_read) begin
               cmd.wrap = 1'b1;
               state_in = status.in_range ? S_SEEK : S_MOD;
            end else begin
               cmd.do_write = 1'b1;
               state_in     = S_OUTPUT;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               state_in = S_MOD_FIX;
            end
         end
         S_MOD_FIX: begin
            cmd.mod_fix = 1'b1;
            state_in    = S_SEEK;
         end
         S_SEEK: begin
            cmd.seek = 1'b1;
            cnt_in   = '0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            // Reads issue on the first four counts; each is captured from the registered read port at the next count.
            cmd.rd_issue   = cnt_ff < CNT_W'(FETCH_TAPS);
            cmd.rd_capture = cnt_ff != '0;
            cnt_in         = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FETCH_TAPS)) begin
               state_in = S_COEF;
            end
         end
         S_COEF: begin
            cmd.coef = 1'b1;
            step_in  = '0;
            state_in = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc = 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               state_in = S_FINISH;
            end else begin
               step_in  = step_ff + STEP_W'(1);
               state_in = S_MUL_LO;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUTPUT;
         end
         S_OUTPUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

[dv/tb.sv]
// Self-checking testbench for ring_capture_cubic_interp_core: stereo capture store writes and
// Catmull-Rom cubic reads, checked against a predictor with its own store and register copy.
// Depends on rci_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb import rci_pkg::*; ();

   typedef struct {
      action_type                act;
      logic signed [SMP_W-1:0]   smp_l;
      logic signed [SMP_W-1:0]   smp_r;
      logic                      hold;
      logic signed [IDX_W-1:0]   index;
      logic [FRAC_W-1:0]         frac;
   } capture_req_type;

   typedef struct {
      logic signed [SMP_W-1:0]   left_v;
      logic signed [SMP_W-1:0]   right_v;
      logic [WPOS_W-1:0]         wpos;
   } interp_rsp_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_W-1:0]        csr_write_data = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_action = 1'b0;
   logic signed [SMP_W-1:0] req_sample_left = '0;
   logic signed [SMP_W-1:0] req_sample_right = '0;
   logic                    req_hold_capture = 1'b0;
   logic signed [IDX_W-1:0] req_read_index = '0;
   logic [FRAC_W-1:0]       req_read_fraction = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [SMP_W-1:0] rsp_left_value;
   logic signed [SMP_W-1:0] rsp_right_value;
   logic [WPOS_W-1:0]       rsp_write_position;

   ring_capture_cubic_interp_core DUT (.*);

   // Predictor state: its own copy of both stores, the pointer and the registers.
   bit signed [SMP_W-1:0] left_copy [DEPTH];
   bit signed [SMP_W-1:0] right_copy [DEPTH];
   int unsigned           model_wptr = 0;
   logic [CSR_W-1:0]      model_length = 17'd65536;
   logic [CHAN_W-1:0]     model_channels = 2'd2;

   capture_req_type req_backlog [$];
   interp_rsp_type  owed_rsp [$];
   capture_req_type on_port;
   int              gap_left = 0;
   int              mismatches = 0;
   int              checked_count = 0;
   bit              quiet = 1'b0;
   int              hold_left = 0;
   int              long_holds = 0;
   int              stall_left = 0;
   int              free_left = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int unsigned ring_len();
      int unsigned l;
      l = 32'(model_length);
      if (l < LEN_MIN) l = LEN_MIN;
      if (l > DEPTH) l = DEPTH;
      return l;
   endfunction

   // Divide by 2^s, rounding to nearest with ties toward plus infinity.
   function automatic longint round_half_up(input longint x, input int s);
      return (x + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic logic signed [SMP_W-1:0] cubic_at(input bit from_right,
         input int unsigned len, input int unsigned i1, input longint f);
      int unsigned i0, i2, i3;
      longint      y0, y1, y2, y3, c1, c2, c3, acc, r;
      i0 = (i1 + len - 1) % len;
      i2 = (i1 + 1) % len;
      i3 = (i1 + 2) % len;
      y0 = longint'(from_right ? right_copy[i0] : left_copy[i0]);
      y1 = longint'(from_right ? right_copy[i1] : left_copy[i1]);
      y2 = longint'(from_right ? right_copy[i2] : left_copy[i2]);
      y3 = longint'(from_right ? right_copy[i3] : left_copy[i3]);
      c1 = y2 - y0;
      c2 = 2 * y0 - 5 * y1 + 4 * y2 - y3;
      c3 = (y3 - y0) + 3 * (y1 - y2);
      // Horner evaluation in fixed point with 16 guard bits; coefficients are doubled.
      acc = c3 * 65536;
      acc = round_half_up(acc * f, 16) + c2 * 65536;
      acc = round_half_up(acc * f, 16) + c1 * 65536;
      acc = round_half_up(acc * f, 16);
      r = y1 + round_half_up(acc, 17);
      if (r > SMP_MAX) r = SMP_MAX;
      if (r < SMP_MIN) r = SMP_MIN;
      return r[SMP_W-1:0];
   endfunction

   task automatic predict_request(input capture_req_type rq);
      int unsigned    len, w, i1;
      longint         pos;
      bit             mono;
      interp_rsp_type due;
      len = ring_len();
      mono = model_channels < CHAN_STEREO;
      due.left_v = '0;
      due.right_v = '0;
      if (rq.act == ACT_WRITE) begin
         if (!rq.hold) begin
            // A pointer left past a shrunken length restarts at slot zero.
            w = model_wptr;
            if (w >= len) w = 0;
            left_copy[w] = rq.smp_l;
            if (!mono) right_copy[w] = rq.smp_r;
            model_wptr = (w + 1) % len;
         end
      end else begin
         pos = longint'(rq.index);
         if (pos < 0) pos += len;
         else if (pos >= len) pos -= len;
         pos = pos % longint'(len);
         if (pos < 0) pos += len;
         i1 = 32'(pos);
         due.left_v = cubic_at(1'b0, len, i1, rq.frac);
         due.right_v = mono ? due.left_v : cubic_at(1'b1, len, i1, rq.frac);
      end
      due.wpos = model_wptr[WPOS_W-1:0];
      owed_rsp.push_back(due);
   endtask

   always @(posedge clock) begin : drive_req
      capture_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_request(on_port);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               nxt = req_backlog.pop_front();
               on_port = nxt;
               req_valid         <= 1'b1;
               req_action        <= nxt.act;
               req_sample_left   <= nxt.smp_l;
               req_sample_right  <= nxt.smp_r;
               req_hold_capture  <= nxt.hold;
               req_read_index    <= nxt.index;
               req_read_fraction <= nxt.frac;
               if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure: random bursts, free stretches, and two long hold-offs.
   always @(posedge clock) begin : rsp_backpressure
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && long_holds < 2 && checked_count >= 150 + 600 * long_holds) begin
         long_holds++;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = $urandom_range(0, 18);
         free_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 30);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      interp_rsp_type due;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         if (owed_rsp.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            due = owed_rsp.pop_front();
            if (rsp_left_value !== due.left_v) begin
               $error("left_value: expected %0d, got %0d", due.left_v, rsp_left_value);
               mismatches++;
            end
            if (rsp_right_value !== due.right_v) begin
               $error("right_value: expected %0d, got %0d", due.right_v, rsp_right_value);
               mismatches++;
            end
            if (rsp_write_position !== due.wpos) begin
               $error("write_position: expected %0d, got %0d", due.wpos, rsp_write_position);
               mismatches++;
            end
         end
      end
   end

   task automatic push_write(input int l, input int r, input bit hold);
      capture_req_type rq;
      rq.act = ACT_WRITE;
      rq.smp_l = l[SMP_W-1:0];
      rq.smp_r = r[SMP_W-1:0];
      rq.hold = hold;
      rq.index = IDX_W'($urandom);
      rq.frac = FRAC_W'($urandom);
      req_backlog.push_back(rq);
   endtask

   task automatic push_read(input int idx, input int frac);
      capture_req_type rq;
      rq.act = ACT_READ;
      rq.smp_l = SMP_W'($urandom);
      rq.smp_r = SMP_W'($urandom);
      rq.hold = 1'($urandom_range(0, 1));
      rq.index = idx[IDX_W-1:0];
      rq.frac = frac[FRAC_W-1:0];
      req_backlog.push_back(rq);
   endtask

   function automatic int rand_sample();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   // Wait until every request has gone in and every response has come back.
   task automatic settle();
      @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || owed_rsp.size() != 0)
         @(negedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic set_reg(input reg_index_type which, input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value[CSR_W-1:0];
      if (which == REG_BUFFER_LENGTH) model_length = value[CSR_W-1:0];
      else model_channels = value[CHAN_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int          phase_len [9];
      int          phase_chan [9];
      int          phase_cnt [9];
      int          p, k, idx, frac;
      int unsigned len;
      phase_len  = '{16, 5, 64, 4, 65536, 65537, 0, 32, 12};
      phase_chan = '{2, 1, 2, 2, 2, 3, 0, 2, 2};
      phase_cnt  = '{250, 150, 200, 150, 60, 60, 80, 200, 200};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset geometry: full-length store, stereo, everything still zero.
      push_read(131071, 65535);
      push_read(-65536, 0);
      push_write(-32768, 32767, 1'b0);
      settle();

      // Short ring with full-scale samples so the cubic overshoots both rails.
      set_reg(REG_BUFFER_LENGTH, 8);
      set_reg(REG_NUM_CHANNELS, 2);
      push_write(32767, -32768, 1'b0);
      push_write(32767, -32768, 1'b0);
      push_write(-32768, 32767, 1'b0);
      push_read(1, 32768);
      push_read(2, 32768);
      push_read(0, 65535);
      push_read(7, 1);
      push_read(131071, 4321);
      push_read(-65536, 99);
      push_read(-1, 1000);
      push_read(9, 2000);
      push_write(5, 5, 1'b1);
      push_write(16'h1234, -2, 1'b0);
      settle();

      // Shrink below the write pointer, in mono mode.
      set_reg(REG_BUFFER_LENGTH, 4);
      set_reg(REG_NUM_CHANNELS, 0);
      push_read(1, 16384);
      push_write(-7, 99, 1'b0);
      push_read(0, 50000);
      settle();
      set_reg(REG_NUM_CHANNELS, 1);
      push_write(300, -300, 1'b0);
      push_read(3, 30000);
      settle();

      // Out-of-range lengths clamp at both ends; channel code 3 is stereo.
      set_reg(REG_BUFFER_LENGTH, 131071);
      set_reg(REG_NUM_CHANNELS, 3);
      push_read(2, 65535);
      settle();
      set_reg(REG_BUFFER_LENGTH, 3);
      set_reg(REG_NUM_CHANNELS, 2);
      push_read(5, 123);
      settle();

      for (p = 0; p < 9; p++) begin
         set_reg(REG_BUFFER_LENGTH, phase_len[p]);
         set_reg(REG_NUM_CHANNELS, phase_chan[p]);
         quiet = (p == 8);
         len = ring_len();
         for (k = 0; k < phase_cnt[p]; k++) begin
            if ($urandom_range(0, 1)) begin
               push_write(rand_sample(), rand_sample(), $urandom_range(0, 9) == 0);
            end else begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: idx = $urandom_range(0, (len < 128 ? len : 128) - 1);
                  6: idx = $urandom_range(len, 2 * len - 1);
                  7: idx = -int'($urandom_range(1, len));
                  default: idx = int'($urandom_range(0, 196607)) - 65536;
               endcase
               case ($urandom_range(0, 9))
                  8: frac = 0;
                  9: frac = 65535;
                  default: frac = $urandom_range(0, 65535);
               endcase
               push_read(idx, frac);
            end
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
